### rtl/md4_pkg.sv
// ----------------------------------------------------------------------------
// md4_pkg
// shared constants, control types and step tables for the md4 digest core
// ----------------------------------------------------------------------------
package md4_pkg;

   localparam int WORD_W     = 32;
   localparam int BUF_WORDS  = 16;
   localparam int BUF_ADDR_W = $clog2(BUF_WORDS);
   localparam int STEPS      = 48;
   localparam int STEP_W     = $clog2(STEPS);
   localparam int COUNT_W    = 64;
   localparam int DIGEST_W   = 4 * WORD_W;

   localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
   localparam logic [WORD_W-1:0] IV_B = 32'hEFCDAB89;
   localparam logic [WORD_W-1:0] IV_C = 32'h98BADCFE;
   localparam logic [WORD_W-1:0] IV_D = 32'h10325476;
   localparam logic [WORD_W-1:0] K_R2 = 32'h5A827999;
   localparam logic [WORD_W-1:0] K_R3 = 32'h6ED9EBA1;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LAST_POS = 6'd63;

   // commands from the byte sequencer to the compression unit
   typedef struct packed {
      logic start;   // block in buffer is complete, begin 48 steps
      logic init;    // reload chaining words with the initial values
   } comp_ctl_type;

   // status back from the compression unit
   typedef struct packed {
      logic busy;
      logic done;    // chaining words updated this cycle
   } comp_stat_type;

   // message word used by a step: round 2 swaps index nibble halves,
   // round 3 bit-reverses the index
   function automatic logic [BUF_ADDR_W-1:0] msg_index(input logic [STEP_W-1:0] step);
      logic [3:0] j;
      j = step[3:0];
      if (step < 6'd16)
         return j;
      else if (step < 6'd32)
         return {j[1:0], j[3:2]};
      else
         return {j[0], j[1], j[2], j[3]};
   endfunction

   function automatic logic [4:0] rot_amount(input logic [STEP_W-1:0] step);
      logic [4:0] amt;
      amt = 5'd3;
      if (step < 6'd16) begin
         case (step[1:0])
            2'd0:    amt = 5'd3;
            2'd1:    amt = 5'd7;
            2'd2:    amt = 5'd11;
            default: amt = 5'd19;
         endcase
      end else if (step < 6'd32) begin
         case (step[1:0])
            2'd0:    amt = 5'd3;
            2'd1:    amt = 5'd5;
            2'd2:    amt = 5'd9;
            default: amt = 5'd13;
         endcase
      end else begin
         case (step[1:0])
            2'd0:    amt = 5'd3;
            2'd1:    amt = 5'd9;
            2'd2:    amt = 5'd11;
            default: amt = 5'd15;
         endcase
      end
      return amt;
   endfunction

   function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                                input logic [4:0] s);
      logic [2*WORD_W-1:0] dbl;
      dbl = {v, v} << s;
      return dbl[2*WORD_W-1:WORD_W];
   endfunction

endpackage

### rtl/md4_ram.sv
// ----------------------------------------------------------------------------
// md4_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module md4_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/md4_comp.sv
// ----------------------------------------------------------------------------
// md4_comp
// 48-step compression unit, one step per cycle, message words from the buffer
// ----------------------------------------------------------------------------
module md4_comp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  md4_pkg::comp_ctl_type                ctl,
   output md4_pkg::comp_stat_type               stat,
   output logic                                 rd_en,
   output logic [md4_pkg::BUF_ADDR_W-1:0]       rd_addr,
   input  logic [md4_pkg::WORD_W-1:0]           rd_data,
   output logic [md4_pkg::DIGEST_W-1:0]         digest
);

   typedef enum logic [1:0] {IDLE, RUN, FOLD} comp_state_type;

   comp_state_type                state_ff;
   logic [md4_pkg::STEP_W-1:0]    step_ff;
   logic [md4_pkg::WORD_W-1:0]    a_ff, b_ff, c_ff, d_ff;
   logic [md4_pkg::WORD_W-1:0]    h0_ff, h1_ff, h2_ff, h3_ff;
   logic [md4_pkg::WORD_W-1:0]    f_val, sum_val, new_val;
   logic [md4_pkg::STEP_W-1:0]    step_next;

   // round function with its additive constant folded in
   always_comb begin
      if (step_ff < 6'd16)
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
      else if (step_ff < 6'd32)
         f_val = ((b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff)) + md4_pkg::K_R2;
      else
         f_val = (b_ff ^ c_ff ^ d_ff) + md4_pkg::K_R3;
      sum_val = a_ff + f_val + rd_data;
      new_val = md4_pkg::rotl32(sum_val, md4_pkg::rot_amount(step_ff));
   end

   // read one step ahead so the word arrives with its step
   assign step_next = step_ff + 1'b1;
   assign rd_en     = ctl.start ||
                      (state_ff == RUN && step_ff != md4_pkg::STEPS[md4_pkg::STEP_W-1:0] - 1'b1);
   assign rd_addr   = ctl.start ? '0 : md4_pkg::msg_index(step_next);

   assign stat      = '{busy: (state_ff != IDLE), done: (state_ff == FOLD)};
   assign digest    = {h3_ff, h2_ff, h1_ff, h0_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         step_ff  <= '0;
         h0_ff    <= md4_pkg::IV_A;
         h1_ff    <= md4_pkg::IV_B;
         h2_ff    <= md4_pkg::IV_C;
         h3_ff    <= md4_pkg::IV_D;
      end else begin
         case (state_ff)
            IDLE: begin
               if (ctl.init) begin
                  h0_ff <= md4_pkg::IV_A;
                  h1_ff <= md4_pkg::IV_B;
                  h2_ff <= md4_pkg::IV_C;
                  h3_ff <= md4_pkg::IV_D;
               end
               if (ctl.start) begin
                  a_ff     <= h0_ff;
                  b_ff     <= h1_ff;
                  c_ff     <= h2_ff;
                  d_ff     <= h3_ff;
                  step_ff  <= '0;
                  state_ff <= RUN;
               end
            end
            RUN: begin
               // rotate roles: next step updates the old d
               a_ff    <= d_ff;
               b_ff    <= new_val;
               c_ff    <= b_ff;
               d_ff    <= c_ff;
               step_ff <= step_next;
               if (step_ff == md4_pkg::STEPS[md4_pkg::STEP_W-1:0] - 1'b1) begin
                  state_ff <= FOLD;
               end
            end
            FOLD: begin
               h0_ff    <= h0_ff + a_ff;
               h1_ff    <= h1_ff + b_ff;
               h2_ff    <= h2_ff + c_ff;
               h3_ff    <= h3_ff + d_ff;
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> state_ff == IDLE)
      else $error("compression started while busy");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == RUN |-> step_ff < md4_pkg::STEPS[md4_pkg::STEP_W-1:0])
      else $error("step counter past last step");

endmodule

### rtl/md4_message_digest_core.sv
// ----------------------------------------------------------------------------
// md4_message_digest_core
// md4 hash of a byte stream, one message byte per input word
// ----------------------------------------------------------------------------
// usage:
//   req channel carries one message byte per word in req_tdata; req_tuser
//   says the byte is real, req_tlast closes the message. a word with
//   req_tlast high and req_tuser low finishes without a byte (empty message
//   right after reset is allowed). a word with both low does nothing.
//   rsp channel carries one word per message: the four chaining words,
//   word 0 in the low 32 bits, each holding digest bytes little-endian.
// throughput:
//   bytes are taken one per cycle. the 64th byte of a block starts the
//   compression unit (48 steps plus a fold state), so req_tready is low
//   while every block compresses.
// finishing:
//   after the last word one pad byte is placed per cycle (9 to 72 bytes),
//   paused while each full pad block compresses; rsp_tvalid rises after
//   the block holding the bit length has compressed.
// reset and stall:
//   reset restores the initial chaining words and a zero byte count. the
//   result waits in an output register while rsp_tready is low and the next
//   message is taken meanwhile; only a second digest waits for it.
// ----------------------------------------------------------------------------
module md4_message_digest_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // data_byte
   input  logic                          req_tuser,   // byte_present
   input  logic                          req_tlast,   // last_item
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [md4_pkg::DIGEST_W-1:0]  rsp_tdata    // digest_word_0..3
);

   typedef enum logic [1:0] {COLLECT, COMPRESS, PAD, EMIT} seq_state_type;

   seq_state_type                   state_ff, state_in;
   logic [md4_pkg::COUNT_W-1:0]     count_ff, count_in, count_plus;
   logic [md4_pkg::COUNT_W-1:0]     bits_ff, bits_in;
   logic [md4_pkg::WORD_W-1:0]      word_ff, word_in;
   logic                            finishing_ff, finishing_in;
   logic                            sent80_ff, sent80_in;
   logic                            fill_ff, fill_in;
   logic                            len_done_ff, len_done_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [md4_pkg::DIGEST_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                            absorb_en;
   logic [7:0]                      absorb_byte;
   logic [5:0]                      pos;
   logic                            wr_en;
   logic                            rd_en;
   logic [md4_pkg::BUF_ADDR_W-1:0]  rd_addr;
   logic [md4_pkg::WORD_W-1:0]      rd_data;
   logic [md4_pkg::DIGEST_W-1:0]    digest;
   md4_pkg::comp_ctl_type           comp_ctl;
   md4_pkg::comp_stat_type          comp_stat;

   assign pos        = count_ff[5:0];
   assign count_plus = count_ff + md4_pkg::COUNT_W'(req_tuser);
   assign req_tready = (state_ff == COLLECT);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      bits_in      = bits_ff;
      word_in      = word_ff;
      finishing_in = finishing_ff;
      sent80_in    = sent80_ff;
      fill_in      = fill_ff;
      len_done_in  = len_done_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      absorb_en    = 1'b0;
      absorb_byte  = req_tdata;
      comp_ctl     = '0;
      wr_en        = 1'b0;

      case (state_ff)
         COLLECT: begin
            if (req_tvalid) begin
               absorb_en = req_tuser;
               if (req_tlast) begin
                  // bit length covers the closing byte if there is one
                  finishing_in = 1'b1;
                  bits_in      = {count_plus[md4_pkg::COUNT_W-4:0], 3'b000};
                  state_in     = PAD;
               end
            end
         end
         COMPRESS: begin
            if (comp_stat.done) begin
               if (len_done_ff)
                  state_in = EMIT;
               else if (finishing_ff)
                  state_in = PAD;
               else
                  state_in = COLLECT;
            end
         end
         PAD: begin
            absorb_en = 1'b1;
            sent80_in = 1'b1;
            if (!sent80_ff) begin
               absorb_byte = md4_pkg::PAD_MARK;
               // marker landed in the length slot: the rest of this block is zero fill
               if (pos[5:3] == 3'b111) fill_in = 1'b1;
            end else if (pos[5:3] == 3'b111 && !fill_ff) begin
               absorb_byte = bits_ff[{pos[2:0], 3'b000} +: 8];
               if (pos == md4_pkg::LAST_POS) len_done_in = 1'b1;
            end else begin
               absorb_byte = 8'h00;
            end
            if (pos == md4_pkg::LAST_POS) fill_in = 1'b0;
         end
         EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = digest;
               comp_ctl.init = 1'b1;
               count_in      = '0;
               finishing_in  = 1'b0;
               sent80_in     = 1'b0;
               fill_in       = 1'b0;
               len_done_in   = 1'b0;
               state_in      = COLLECT;
            end
         end
         default: state_in = COLLECT;
      endcase

      // shared byte path: merge into the word, write it out on its top lane
      if (absorb_en) begin
         count_in                       = count_ff + 1'b1;
         word_in[{pos[1:0], 3'b000} +: 8] = absorb_byte;
         wr_en                          = (pos[1:0] == 2'b11);
         if (pos == md4_pkg::LAST_POS) begin
            comp_ctl.start = 1'b1;
            state_in       = COMPRESS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= COLLECT;
         count_ff     <= '0;
         finishing_ff <= 1'b0;
         sent80_ff    <= 1'b0;
         fill_ff      <= 1'b0;
         len_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         finishing_ff <= finishing_in;
         sent80_ff    <= sent80_in;
         fill_ff      <= fill_in;
         len_done_ff  <= len_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bits_ff     <= bits_in;
      word_ff     <= word_in;
      rsp_data_ff <= rsp_data_in;
   end

   md4_ram #(
      .DATA_W (md4_pkg::WORD_W),
      .DEPTH  (md4_pkg::BUF_WORDS)
   ) u_block_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos[5:2]),
      .wr_data (word_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   md4_comp u_comp (
      .clock   (clock),
      .reset   (reset),
      .ctl     (comp_ctl),
      .stat    (comp_stat),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .digest  (digest)
   );

   a_no_take_while_busy: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !comp_stat.busy)
      else $error("input taken while compression runs");

   a_length_block_aligned: assert property (@(posedge clock) disable iff (reset)
      (comp_stat.done && len_done_ff) |-> count_ff[5:0] == 6'd0)
      else $error("length block did not end on a block boundary");

   a_pad_only_finishing: assert property (@(posedge clock) disable iff (reset)
      state_ff == PAD |-> finishing_ff)
      else $error("padding without a closing word");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for md4_message_digest_core: byte streams go in on the
// req channel, a bit-true md4 predictor forms the digest of each message,
// and every digest word on the rsp channel is checked against it in order
// ----------------------------------------------------------------------------
module testbench;

   localparam int CLOCK_PERIOD  = 10;
   localparam int RESET_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 400;    // longer than pad plus two compressions
   localparam int MAX_REPORTS   = 10;
   localparam int PHASE_WORDS   = 110;
   localparam int PHASE_DIGESTS = 3;

   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [7:0]                   req_tdata  = 8'h00;   // data_byte
   logic                         req_tuser  = 1'b0;    // byte_present
   logic                         req_tlast  = 1'b0;    // last_item
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [md4_pkg::DIGEST_W-1:0] rsp_tdata;            // digest_word_0..3

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int error_count    = 0;
   int cycle_count    = 0;
   int words_sent     = 0;   // bytes and finishes, idle words not counted

   // predictor state
   logic [md4_pkg::WORD_W-1:0]   hash_chain [4];
   logic [md4_pkg::WORD_W-1:0]   hash_block [16];
   logic [63:0]                  hash_bytes;
   logic [md4_pkg::DIGEST_W-1:0] expected_digests [$];
   logic [md4_pkg::DIGEST_W-1:0] next_digest;

   md4_message_digest_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic logic [md4_pkg::WORD_W-1:0] rotate_left(
         input logic [md4_pkg::WORD_W-1:0] v, input int n);
      return (v << n) | (v >> (md4_pkg::WORD_W - n));
   endfunction

   function automatic int step_shift(input int step);
      int col;
      int amount;
      col = step % 4;
      case (step / 16)
         0:       amount = (col == 0) ? 3 : (col == 1) ? 7 : (col == 2) ? 11 : 19;
         1:       amount = (col == 0) ? 3 : (col == 1) ? 5 : (col == 2) ? 9 : 13;
         default: amount = (col == 0) ? 3 : (col == 1) ? 9 : (col == 2) ? 11 : 15;
      endcase
      return amount;
   endfunction

   // round 2 walks the words column-wise, round 3 in bit-reversed order
   function automatic int step_word(input int step);
      logic [3:0] j;
      int         index;
      j = step[3:0];
      case (step / 16)
         0:       index = j;
         1:       index = (j % 4) * 4 + j / 4;
         default: index = {j[0], j[1], j[2], j[3]};
      endcase
      return index;
   endfunction

   function automatic void compress_block();
      logic [md4_pkg::WORD_W-1:0] a, b, c, d, mix, rolled;
      int step;
      a = hash_chain[0];
      b = hash_chain[1];
      c = hash_chain[2];
      d = hash_chain[3];
      for (step = 0; step < 48; step++) begin
         case (step / 16)
            0:       mix = (b & c) | (~b & d);
            1:       mix = ((b & c) | (b & d) | (c & d)) + md4_pkg::K_R2;
            default: mix = (b ^ c ^ d) + md4_pkg::K_R3;
         endcase
         rolled = rotate_left(a + mix + hash_block[step_word(step)], step_shift(step));
         // the updated register moves to b, the rest shift down one place
         a = d;
         d = c;
         c = b;
         b = rolled;
      end
      hash_chain[0] += a;
      hash_chain[1] += b;
      hash_chain[2] += c;
      hash_chain[3] += d;
   endfunction

   function automatic void absorb_byte(input logic [7:0] v);
      int w;
      int sh;
      w  = hash_bytes[5:2];
      sh = 8 * hash_bytes[1:0];
      hash_block[w][sh +: 8] = v;
      hash_bytes = hash_bytes + 64'd1;
      if (hash_bytes[5:0] == 6'd0) compress_block();
   endfunction

   function automatic void restart_hash();
      hash_chain[0] = md4_pkg::IV_A;
      hash_chain[1] = md4_pkg::IV_B;
      hash_chain[2] = md4_pkg::IV_C;
      hash_chain[3] = md4_pkg::IV_D;
      hash_bytes    = 64'd0;
   endfunction

   // pad mark, zeros up to 56 mod 64, then the bit length little-endian
   function automatic logic [md4_pkg::DIGEST_W-1:0] finish_digest();
      logic [63:0]                  bit_length;
      logic [md4_pkg::DIGEST_W-1:0] digest;
      int k;
      bit_length = hash_bytes << 3;
      absorb_byte(md4_pkg::PAD_MARK);
      while (hash_bytes[5:0] != 6'd56) absorb_byte(8'h00);
      for (k = 0; k < 8; k++) absorb_byte(bit_length[8*k +: 8]);
      digest = {hash_chain[3], hash_chain[2], hash_chain[1], hash_chain[0]};
      restart_hash();
      return digest;
   endfunction

   function automatic void predict_word(input logic [7:0] data_byte,
                                        input logic byte_present, input logic last_item);
      logic [md4_pkg::DIGEST_W-1:0] digest;
      if (byte_present) absorb_byte(data_byte);
      if (last_item) begin
         digest           = finish_digest();
         expected_digests = {expected_digests, digest};
      end
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void report_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("cycle %0d: %s", cycle_count, msg);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_digests.size() == 0) begin
            report_error($sformatf("digest %032h with no finished message", rsp_tdata));
         end else begin
            next_digest = expected_digests.pop_front();
            for (int k = 0; k < 4; k++)
               if (rsp_tdata[md4_pkg::WORD_W*k +: md4_pkg::WORD_W] !==
                   next_digest[md4_pkg::WORD_W*k +: md4_pkg::WORD_W])
                  report_error($sformatf("digest_word_%0d expected %08h got %08h", k,
                                         next_digest[md4_pkg::WORD_W*k +: md4_pkg::WORD_W],
                                         rsp_tdata[md4_pkg::WORD_W*k +: md4_pkg::WORD_W]));
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("md4_message_digest_core test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic send_word(input logic [7:0] data_byte, input logic byte_present,
                            input logic last_item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data_byte;
      req_tuser  <= byte_present;
      req_tlast  <= last_item;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_word(data_byte, byte_present, last_item);
      if (byte_present || last_item) words_sent++;
   endtask

   // sender holds off until every digest owed has come back
   task automatic wait_for_digests();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_digests.size() != 0) @(posedge clock);
   endtask

   // random bytes with the odd idle word mixed in; the message closes either
   // on its last byte or with a bare finish
   task automatic send_message(input int len);
      logic close_on_byte;
      int i;
      close_on_byte = (len > 0) && ($urandom_range(1) == 1);
      for (i = 0; i < len; i++) begin
         if ($urandom_range(99) < 4) send_word(8'($urandom_range(255)), 1'b0, 1'b0);
         send_word(8'($urandom_range(255)), 1'b1, close_on_byte && (i == len - 1));
      end
      if (!close_on_byte) send_word(8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   // empty and one-byte lengths and lengths around the 56 and 64 byte pad boundaries get extra weight
   function automatic int pick_length();
      int roll;
      int len;
      roll = $urandom_range(99);
      if (roll < 25) begin
         case ($urandom_range(9))
            0:       len = 0;
            1:       len = 1;
            2:       len = 55;
            3:       len = 56;
            4:       len = 57;
            5:       len = 63;
            6:       len = 64;
            7:       len = 65;
            8:       len = 119;
            default: len = 120;
         endcase
      end else if (roll < 85) begin
         len = $urandom_range(24);
      end else begin
         len = $urandom_range(140, 25);
      end
      return len;
   endfunction

   // empty messages: bare finish right after reset and after an idle word
   task automatic test_empty_message();
      send_word(8'h00, 1'b0, 1'b1);
      send_word(8'hFF, 1'b0, 1'b0);
      send_word(8'hA5, 1'b0, 1'b1);
   endtask

   // byte extremes, a byte carried on the last word, idle words mid-message
   task automatic test_byte_extremes();
      send_word(8'h61, 1'b1, 1'b1);
      send_word(8'h00, 1'b1, 1'b0);
      send_word(8'hFF, 1'b1, 1'b0);
      send_word(8'hFF, 1'b0, 1'b0);
      send_word(8'h80, 1'b1, 1'b1);
      send_word(8'hFF, 1'b1, 1'b1);
      send_word(8'h00, 1'b1, 1'b1);
      send_word(8'h61, 1'b1, 1'b0);
      send_word(8'h62, 1'b1, 1'b0);
      send_word(8'h00, 1'b0, 1'b0);
      send_word(8'h63, 1'b1, 1'b0);
      send_word(8'h55, 1'b0, 1'b1);
   endtask

   task automatic test_random_messages(input int idle_pct, input int stall_pct);
      int start_words;
      int messages;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      start_words    = words_sent;
      messages       = 0;
      while (words_sent - start_words < PHASE_WORDS || messages < PHASE_DIGESTS) begin
         send_message(pick_length());
         messages++;
      end
   endtask

   initial begin
      restart_hash();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_empty_message();
      test_byte_extremes();
      wait_for_digests();

      test_random_messages(0, 0);
      wait_for_digests();
      test_random_messages(73, 0);
      wait_for_digests();
      test_random_messages(0, 73);
      wait_for_digests();
      test_random_messages(22, 22);
      wait_for_digests();

      // catch any stray digest after the last message
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("md4_message_digest_core test passed");
      end else begin
         $display("md4_message_digest_core test failed");
      end
      $finish;
   end

endmodule

### files.f
rtl/md4_pkg.sv
rtl/md4_ram.sv
rtl/md4_comp.sv
rtl/md4_message_digest_core.sv
tb/testbench.sv
